// ===== sv/sqt_pkg.sv =====
// Package for the streaming quantile tree core.
// Holds the tree size, field widths and the controller-to-datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps

package sqt_pkg;

	localparam int NUM_ENTRIES = 15;
	localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

	localparam int SAMPLE_W = 64;
	localparam int VAL_W    = 32;
	localparam int ENTRY_W  = 4;

	localparam logic [VAL_W-1:0] STEP_FLOOR_INIT = 32'd1024;
	localparam logic [VAL_W-1:0] EST_MAX         = 32'hFFFF_FFFF;
	localparam logic [VAL_W-1:0] STEP_MIN        = 32'd1;

	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	typedef struct packed {
		logic load;
		logic adj;
		logic wb;
		logic out_load;
	} sqt_cmd_t;

	typedef struct packed {
		logic is_read;
		logic walk_more;
	} sqt_sts_t;

endpackage

// ===== sv/sqt_ctrl.sv =====
// Controller of the streaming quantile tree core.
// Sequences input capture, the per-node update and result hand-off; depends on sqt_pkg.
`timescale 1ns / 1ps

module sqt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  sqt_pkg::sqt_sts_t sts,
	output sqt_pkg::sqt_cmd_t cmd
);
	import sqt_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ADJ  = 4'b0010,
		ST_WB   = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.adj      = 1'b0;
		cmd.wb       = 1'b0;
		cmd.out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_ADJ;
				end
			end
			ST_ADJ: begin
				if (sts.is_read) begin
					state_d = ST_FIN;
				end else begin
					cmd.adj = 1'b1;
					state_d = ST_WB;
				end
			end
			ST_WB: begin
				cmd.wb  = 1'b1;
				state_d = sts.walk_more ? ST_ADJ : ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/sqt_dp.sv =====
// Datapath of the streaming quantile tree core.
// Holds the estimate and step tables, the node update arithmetic and the result register;
// depends on sqt_pkg.
`timescale 1ns / 1ps

module sqt_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sqt_pkg::sqt_cmd_t               cmd,
	output sqt_pkg::sqt_sts_t               sts,
	input  logic                            func,
	input  logic [sqt_pkg::SAMPLE_W-1:0]    sample,
	input  logic [sqt_pkg::ENTRY_W-1:0]     entry_index,
	output logic [sqt_pkg::ENTRY_W-1:0]     node,
	output logic [sqt_pkg::VAL_W-1:0]       estimate,
	output logic [sqt_pkg::VAL_W-1:0]       step_size
);
	import sqt_pkg::*;

	logic [VAL_W-1:0]    est_q [NUM_ENTRIES];
	logic [VAL_W-1:0]    stp_q [NUM_ENTRIES];

	logic                func_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [ENTRY_W-1:0]  idx_q;
	logic [IDX_W-1:0]    node_q;

	logic [VAL_W-1:0]    m_s1;
	logic [VAL_W-1:0]    s_s1;

	logic [ENTRY_W-1:0]  res_node_q;
	logic [VAL_W-1:0]    res_est_q;
	logic [VAL_W-1:0]    res_stp_q;

	logic [VAL_W-1:0]    m_cur, s_cur, m_new, s_new;
	logic [VAL_W-1:0]    half;
	logic [VAL_W:0]      sum;
	logic [SAMPLE_W-1:0] m_ext, diff;
	logic [VAL_W-1:0]    s_half, s_fin;
	logic                stop;
	logic [IDX_W:0]      next_w;
	logic [IDX_W-1:0]    rd_addr;
	logic                rd_in_range;

	assign m_cur = est_q[node_q];
	assign s_cur = stp_q[node_q];
	assign half  = sample_q[VAL_W:1];
	assign sum   = {1'b0, m_cur} + {1'b0, s_cur};

	always_comb begin
		m_new = m_cur;
		s_new = s_cur;
		if (s_cur == '0) begin
			m_new = sample_q[VAL_W-1:0];
			s_new = (half > STEP_FLOOR_INIT) ? half : STEP_FLOOR_INIT;
		end else if ({{(SAMPLE_W-VAL_W){1'b0}}, m_cur} > sample_q) begin
			m_new = (m_cur >= s_cur) ? (m_cur - s_cur) : '0;
		end else if ({{(SAMPLE_W-VAL_W){1'b0}}, m_cur} < sample_q) begin
			m_new = sum[VAL_W] ? EST_MAX : sum[VAL_W-1:0];
		end
	end

	assign m_ext  = {{(SAMPLE_W-VAL_W){1'b0}}, m_s1};
	assign diff   = (m_ext > sample_q) ? (m_ext - sample_q) : (sample_q - m_ext);
	assign s_half = s_s1 >> 1;
	assign s_fin  = (diff < {{(SAMPLE_W-VAL_W){1'b0}}, s_s1}) ?
	                ((s_half == '0) ? STEP_MIN : s_half) : s_s1;
	assign stop   = (sample_q >= m_ext);
	assign next_w = {node_q, 1'b1};

	assign sts.is_read   = (func_q == FUNC_READ);
	assign sts.walk_more = !stop && (next_w < (IDX_W+1)'(NUM_ENTRIES));

	assign rd_addr     = (func_q == FUNC_READ) ? IDX_W'(idx_q) : node_q;
	assign rd_in_range = (func_q != FUNC_READ) || (32'(idx_q) < 32'(NUM_ENTRIES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				est_q[i] <= '0;
				stp_q[i] <= '0;
			end
		end else if (cmd.wb) begin
			est_q[node_q] <= m_s1;
			stp_q[node_q] <= s_fin;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			sample_q <= sample;
			idx_q    <= entry_index;
			node_q   <= '0;
		end else if (cmd.wb && sts.walk_more) begin
			node_q <= next_w[IDX_W-1:0];
		end
		if (cmd.adj) begin
			m_s1 <= m_new;
			s_s1 <= s_new;
		end
		if (cmd.out_load) begin
			res_node_q <= (func_q == FUNC_READ) ? idx_q : ENTRY_W'(node_q);
			res_est_q  <= rd_in_range ? est_q[rd_addr] : '0;
			res_stp_q  <= rd_in_range ? stp_q[rd_addr] : '0;
		end
	end

	assign node      = res_node_q;
	assign estimate  = res_est_q;
	assign step_size = res_stp_q;

endmodule

// ===== sv/streaming_quantile_tree_core.sv =====
// Streaming quantile tree core: frugal quantile estimates kept in a small Eytzinger-ordered tree.
// Top level; instantiates sqt_ctrl and sqt_dp and depends on sqt_pkg.
//
// Usage:
// The input channel (in_valid, in_ready) carries one item: func, sample and entry_index.
// func selects an update of the tree with sample or a read of entry entry_index.
// The output channel (out_valid, out_ready) returns one result item per input item:
// node, estimate and step_size of the last node touched by an update, or of the entry read.
// A read of an entry beyond the tree returns zero estimate and step.
// A read passes through the adjust state and the finish state before its result is loaded.
// An update passes through an adjust state, which adjusts the estimate, and a write-back
// state, which settles the step and writes it back, for each node it visits, and visits
// at most the depth of the leftmost path (four nodes here). Items are handled one at a
// time; in_ready is high only when the core is idle and rises with out_valid, so a new
// item is taken only once the last result has gone to the output register.
// The result sits in an output register, so the next item is accepted and worked on while
// a result still waits; if the receiver stalls, the finished item waits until that
// register is free and input stalls behind it.
// Reset clears every estimate and step to zero (uninitialised) and drops any pending item.
`timescale 1ns / 1ps

module streaming_quantile_tree_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         func,
	input  logic [sqt_pkg::SAMPLE_W-1:0] sample,
	input  logic [sqt_pkg::ENTRY_W-1:0]  entry_index,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sqt_pkg::ENTRY_W-1:0]  node,
	output logic [sqt_pkg::VAL_W-1:0]    estimate,
	output logic [sqt_pkg::VAL_W-1:0]    step_size
);
	import sqt_pkg::*;

	sqt_cmd_t cmd;
	sqt_sts_t sts;

	sqt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sqt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (func),
		.sample      (sample),
		.entry_index (entry_index),
		.node        (node),
		.estimate    (estimate),
		.step_size   (step_size)
	);

endmodule

// ===== bench/streaming_quantile_tree_core_tb.sv =====
// Self-checking testbench for streaming_quantile_tree_core: updates and reads of the estimate tree.
// A scoreboard class predicts every result item; depends on sqt_pkg and the core RTL.
`timescale 1ns / 1ps

module streaming_quantile_tree_core_tb;

	import sqt_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400_000;

	typedef struct packed {
		logic [ENTRY_W-1:0] node;
		logic [VAL_W-1:0]   estimate;
		logic [VAL_W-1:0]   step_size;
	} tree_result_t;

	class quantile_tree_scoreboard;
		logic [VAL_W-1:0] node_est [NUM_ENTRIES];
		logic [VAL_W-1:0] node_step [NUM_ENTRIES];
		tree_result_t     awaited_results[$];
		int               mismatches;

		function new();
			foreach (node_est[n]) begin
				node_est[n]  = '0;
				node_step[n] = '0;
			end
			mismatches = 0;
		endfunction

		function int outstanding();
			return awaited_results.size();
		endfunction

		function logic [VAL_W-1:0] estimate_at(int n);
			return node_est[n];
		endfunction

		function logic [VAL_W-1:0] adjust_node(int n, logic [SAMPLE_W-1:0] v);
			logic [VAL_W-1:0]    m;
			logic [VAL_W-1:0]    s;
			logic [VAL_W-1:0]    half;
			logic [VAL_W-1:0]    sum;
			logic [SAMPLE_W-1:0] wide_m;
			logic [SAMPLE_W-1:0] diff;
			m = node_est[n];
			s = node_step[n];
			wide_m = {32'd0, m};
			if (s == '0) begin
				half = v[32:1];
				m    = v[31:0];
				s    = (half > STEP_FLOOR_INIT) ? half : STEP_FLOOR_INIT;
			end else if (wide_m > v) begin
				m = (m >= s) ? m - s : '0;
			end else if (wide_m < v) begin
				sum = m + s;
				m   = (sum > m) ? sum : EST_MAX;
			end
			wide_m = {32'd0, m};
			diff   = (wide_m > v) ? wide_m - v : v - wide_m;
			if (diff < {32'd0, s})
				s = ((s >> 1) > STEP_MIN) ? (s >> 1) : STEP_MIN;
			node_est[n]  = m;
			node_step[n] = s;
			return m;
		endfunction

		function void note_item(logic f, logic [SAMPLE_W-1:0] v, logic [ENTRY_W-1:0] idx);
			tree_result_t     r;
			int unsigned      i;
			int unsigned      last;
			logic [VAL_W-1:0] m;
			if (f == FUNC_READ) begin
				r.node = idx;
				if (idx < NUM_ENTRIES) begin
					r.estimate  = node_est[idx];
					r.step_size = node_step[idx];
				end else begin
					r.estimate  = '0;
					r.step_size = '0;
				end
			end else begin
				i    = 0;
				last = 0;
				while (i < NUM_ENTRIES) begin
					m    = adjust_node(i, v);
					last = i;
					if (v >= {32'd0, m})
						break;
					// The sample is below the estimate here, so the walk always goes left.
					i = 2 * i + 1;
				end
				r.node      = last[ENTRY_W-1:0];
				r.estimate  = node_est[last];
				r.step_size = node_step[last];
			end
			awaited_results.push_back(r);
		endfunction

		function void check_result(logic [ENTRY_W-1:0] n, logic [VAL_W-1:0] e,
				logic [VAL_W-1:0] s);
			tree_result_t want;
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: node %0d estimate %0h step %0h", n, e, s);
				return;
			end
			want = awaited_results.pop_front();
			if (want.node !== n || want.estimate !== e || want.step_size !== s) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected node %0d estimate %0h step %0h, ",
						"got node %0d estimate %0h step %0h"},
						want.node, want.estimate, want.step_size, n, e, s);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                func = FUNC_UPDATE;
	logic [SAMPLE_W-1:0] sample = '0;
	logic [ENTRY_W-1:0]  entry_index = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [ENTRY_W-1:0]  node;
	logic [VAL_W-1:0]    estimate;
	logic [VAL_W-1:0]    step_size;

	quantile_tree_scoreboard sb;
	logic                    hold_req = 1'b0;
	int unsigned             cycle_count = 0;

	streaming_quantile_tree_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.sample      (sample),
		.entry_index (entry_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.node        (node),
		.estimate    (estimate),
		.step_size   (step_size)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("streaming_quantile_tree_core_tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(node, estimate, step_size);
	end

	task automatic offer_item(input logic f, input logic [SAMPLE_W-1:0] v,
			input logic [ENTRY_W-1:0] idx);
		in_valid    <= 1'b1;
		func        <= f;
		sample      <= v;
		entry_index <= idx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_item(f, v, idx);
	endtask

	task automatic idle_cycles(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic pick_random_item(output logic f, output logic [SAMPLE_W-1:0] v,
			output logic [ENTRY_W-1:0] idx);
		int               sel;
		int unsigned      delta;
		logic [VAL_W-1:0] centre;
		sel = $urandom_range(0, 99);
		idx = ENTRY_W'($urandom_range(0, 15));
		f   = FUNC_UPDATE;
		if (sel < 25) begin
			f = FUNC_READ;
			v = {$urandom, $urandom};
		end else if (sel < 50) begin
			v = SAMPLE_W'($urandom_range(0, 4095));
		end else if (sel < 62) begin
			v = SAMPLE_W'($urandom_range(0, 1 << 20));
		end else if (sel < 74) begin
			v = {32'd0, $urandom};
		end else if (sel < 84) begin
			v = {$urandom, $urandom};
		end else begin
			// Samples close to a held estimate make the steps shrink and the walk go deep.
			centre = sb.estimate_at($urandom_range(0, NUM_ENTRIES - 1));
			delta  = $urandom_range(0, 3000);
			if ($urandom_range(0, 1) == 0)
				v = {32'd0, centre} + {32'd0, delta};
			else
				v = (centre > delta) ? {32'd0, centre - delta} : '0;
		end
	endtask

	initial begin
		int unsigned span;
		int unsigned mode;
		int unsigned period;
		int unsigned hold_left;
		hold_left = 0;
		wait (arst_n);
		forever begin
			span   = $urandom_range(16, 96);
			mode   = $urandom_range(0, 3);
			period = $urandom_range(2, 5);
			for (int c = 0; c < span; c++) begin
				@(posedge clk);
				if (hold_req) begin
					hold_req  = 1'b0;
					hold_left = 300;
				end
				if (hold_left > 0) begin
					hold_left--;
					out_ready <= 1'b0;
				end else begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom_range(0, 1));
						2: out_ready <= (c % period == 0);
						default: out_ready <= ($urandom_range(0, 9) != 0);
					endcase
				end
			end
		end
	end

	initial begin
		logic [SAMPLE_W-1:0] walk_down [10];
		logic [ENTRY_W-1:0]  read_back [4];
		logic                f;
		logic [SAMPLE_W-1:0] v;
		logic [ENTRY_W-1:0]  idx;
		int                  sent;
		int                  burst;
		bit                  pressed;
		bit                  paused;
		walk_down = '{64'd1000, 64'd500, 64'd250, 64'd100, 64'd50, 64'd20, 64'd10, 64'd5,
			64'd1, 64'd0};
		read_back = '{4'd1, 4'd3, 4'd7, 4'd14};
		sb      = new();
		sent    = 0;
		pressed = 1'b0;
		paused  = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_item(FUNC_READ, 64'd0, 4'd0);
		offer_item(FUNC_READ, '1, 4'd15);
		offer_item(FUNC_READ, 64'd0, 4'd14);
		offer_item(FUNC_READ, 64'd0, 4'd7);
		offer_item(FUNC_UPDATE, 64'h0000_0001_FFFF_FFFE, 4'd0);
		offer_item(FUNC_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
		offer_item(FUNC_READ, 64'd0, 4'd0);
		offer_item(FUNC_UPDATE, 64'd0, 4'd0);
		offer_item(FUNC_UPDATE, 64'd0, 4'd0);
		offer_item(FUNC_UPDATE, 64'h0000_0001_0000_0000, 4'd0);
		offer_item(FUNC_UPDATE, 64'h8000_0000_0000_0000, 4'd0);
		foreach (walk_down[k])
			offer_item(FUNC_UPDATE, walk_down[k], 4'd0);
		foreach (read_back[k])
			offer_item(FUNC_READ, 64'd0, read_back[k]);
		wait_all_results();

		while (sent < 1500) begin
			burst = $urandom_range(1, 48);
			for (int k = 0; k < burst; k++) begin
				pick_random_item(f, v, idx);
				offer_item(f, v, idx);
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 15));
			if (!pressed && sent >= 500) begin
				// The receiver holds off while items keep coming, so the core backs up.
				hold_req = 1'b1;
				for (int k = 0; k < 40; k++) begin
					pick_random_item(f, v, idx);
					offer_item(f, v, idx);
				end
				sent += 40;
				pressed = 1'b1;
			end
			if (!paused && sent >= 1000) begin
				wait_all_results();
				idle_cycles($urandom_range(5, 30));
				paused = 1'b1;
			end
		end

		wait_all_results();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("streaming_quantile_tree_core_tb: PASS");
		end else begin
			$display("streaming_quantile_tree_core_tb: FAIL");
		end
		$finish;
	end

endmodule
